>>> sv/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants of the trapezoid motion profile block.
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int TS_BITS      = 17;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACC_MAX  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEC_MAX  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_MAX    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEP = 3'd5;

    typedef enum logic [1:0] {
        MODE_ACC = 2'd0,
        MODE_DEC = 2'd1,
        MODE_CON = 2'd2
    } t_mode;

    typedef struct packed {
        logic load;
        logic keep;
    } t_mult_ctl;

endpackage

>>> sv/tmp_mult.sv
// ----------------------------------------------------------------------------
// tmp_mult
// Bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle,
// top multiplier bit taken with negative weight.
// ----------------------------------------------------------------------------
module tmp_mult #(
    parameter int PW = 68,
    parameter int QW = 34,
    parameter int CW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmp_pkg::t_mult_ctl   i_ctl,
    input  logic signed [PW-1:0] i_mcand,
    input  logic        [QW-1:0] i_mplier,
    input  logic        [CW-1:0] i_nbits,
    output logic signed [PW-1:0] o_acc,
    output logic                 o_done
);
    import tmp_pkg::*;

    logic signed [PW-1:0] r_mcand;
    logic        [QW-1:0] r_mplier;
    logic signed [PW-1:0] r_acc;
    logic        [CW-1:0] r_cnt;
    logic                 r_done;
    logic signed [PW-1:0] n_term;

    assign n_term = r_mplier[0] ? r_mcand : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_mcand  <= i_mcand;
                r_mplier <= i_mplier;
                r_cnt    <= i_nbits;
                r_done   <= 1'b0;
                if (!i_ctl.keep) begin
                    r_acc <= '0;
                end
            end else if (r_cnt != '0) begin
                if (r_cnt == CW'(1)) begin
                    r_acc <= r_acc - n_term;
                end else begin
                    r_acc <= r_acc + n_term;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - CW'(1);
                r_done   <= (r_cnt == CW'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

>>> sv/tmp_core.sv
// ----------------------------------------------------------------------------
// tmp_core
// Tick sequencer: braking test, mode choice, velocity and position update,
// driving the shared bit-serial multiplier, with the result register.
// ----------------------------------------------------------------------------
module tmp_core #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [W-2:0]                  i_acc_max,
    input  logic [W-1:0]                  i_dec_max,
    input  logic [W-2:0]                  i_v_max,
    input  logic [W-1:0]                  i_target,
    input  logic [W-1:0]                  i_stop,
    input  logic [tmp_pkg::TS_BITS-1:0]   i_time_step,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [W-1:0]                  i_vel_noise,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [W-1:0]                  o_position,
    output logic [W-1:0]                  o_velocity,
    output logic [W-1:0]                  o_acceleration,
    output logic [1:0]                    o_mode_before,
    output logic [1:0]                    o_mode_after
);
    import tmp_pkg::*;

    localparam int PW  = 2 * W + 4;
    localparam int QW  = W + 2;
    localparam int CW  = $clog2(QW + 1);
    localparam int SW  = W + 1;
    localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        S_IDLE, S_VV, S_VV_W, S_DD, S_DD_W, S_MODE, S_AT_W,
        S_T, S_VN, S_SUM, S_PS_W, S_POS, S_OUT
    } t_state;

    function automatic logic signed [W-1:0] f_sat(input logic signed [PW-1:0] x);
        logic signed [W-1:0] res;
        if (x > SAT_HI) begin
            res = {1'b0, {(W-1){1'b1}}};
        end else if (x < SAT_LO) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = x[W-1:0];
        end
        return res;
    endfunction

    t_state              r_state;
    logic signed [W-1:0] r_pos;
    logic signed [W-1:0] r_vel;
    t_mode               r_mode;
    t_mode               r_mode_before;
    logic signed [W-1:0] r_noise;
    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_t;
    logic signed [W-1:0] r_vnew;
    logic                r_out_valid;
    logic [W-1:0]        r_o_pos;
    logic [W-1:0]        r_o_vel;
    logic [W-1:0]        r_o_acc;
    logic [1:0]          r_o_mode_before;
    logic [1:0]          r_o_mode_after;

    t_mult_ctl            w_ctl;
    logic signed [PW-1:0] w_mcand;
    logic        [QW-1:0] w_mplier;
    logic        [CW-1:0] w_nbits;
    logic signed [PW-1:0] w_acc;
    logic                 w_done;

    logic signed [QW-1:0] n_d;
    logic                 n_brake;
    logic                 n_at_max;
    logic                 n_stopped;
    t_mode                n_mode;
    logic signed [W-1:0]  n_a;
    logic signed [W-1:0]  n_t;
    logic signed [W-1:0]  n_vnew;
    logic signed [SW-1:0] n_sum;
    logic signed [W-1:0]  n_pos;

    tmp_mult #(
        .PW (PW),
        .QW (QW),
        .CW (CW)
    ) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .i_nbits  (w_nbits),
        .o_acc    (w_acc),
        .o_done   (w_done)
    );

    // distance left short of the stopping margin
    assign n_d = QW'($signed(i_target)) - QW'(r_pos) - QW'($signed(i_stop));

    // 2*dec*d + v*v left in the accumulator
    assign n_brake   = (w_acc > 0);
    assign n_at_max  = (r_vel >= $signed({1'b0, i_v_max}));
    assign n_stopped = (r_vel <= 0);

    always_comb begin
        if (!n_at_max && !n_brake) begin
            n_mode = MODE_ACC;
        end else if (n_stopped) begin
            n_mode = MODE_CON;
        end else if (n_brake) begin
            n_mode = MODE_DEC;
        end else begin
            n_mode = MODE_CON;
        end
    end

    always_comb begin
        unique case (n_mode)
            MODE_DEC: n_a = $signed(i_dec_max);
            MODE_ACC: n_a = $signed({1'b0, i_acc_max});
            default:  n_a = '0;
        endcase
    end

    assign n_t    = f_sat(PW'(r_vel) + (w_acc >>> F));
    assign n_vnew = (r_t <= 0) ? '0 : f_sat(PW'(r_t) + PW'(r_noise));
    assign n_sum  = SW'(r_vnew) + SW'(r_vel);
    assign n_pos  = f_sat(PW'(r_pos) + (w_acc >>> (F + 1)));

    always_comb begin
        w_ctl    = '0;
        w_mcand  = '0;
        w_mplier = '0;
        w_nbits  = '0;
        unique case (r_state)
            S_VV: begin
                w_ctl.load = 1'b1;
                w_mcand    = PW'(r_vel);
                w_mplier   = QW'(r_vel);
                w_nbits    = CW'(W);
            end
            S_DD: begin
                w_ctl.load = 1'b1;
                w_ctl.keep = 1'b1;
                w_mcand    = PW'($signed(i_dec_max)) <<< 1;
                w_mplier   = n_d;
                w_nbits    = CW'(QW);
            end
            S_MODE: begin
                w_ctl.load = 1'b1;
                w_mcand    = PW'(n_a);
                w_mplier   = QW'(i_time_step);
                w_nbits    = CW'(TS_BITS + 1);
            end
            S_SUM: begin
                w_ctl.load = 1'b1;
                w_mcand    = PW'(n_sum);
                w_mplier   = QW'(i_time_step);
                w_nbits    = CW'(TS_BITS + 1);
            end
            default: begin
                w_ctl.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_vel       <= '0;
            r_mode      <= MODE_CON;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_noise       <= $signed(i_vel_noise);
                        r_mode_before <= r_mode;
                        r_state       <= S_VV;
                    end
                end
                S_VV:   r_state <= S_VV_W;
                S_VV_W: if (w_done) r_state <= S_DD;
                S_DD:   r_state <= S_DD_W;
                S_DD_W: if (w_done) r_state <= S_MODE;
                S_MODE: begin
                    r_mode  <= n_mode;
                    r_a     <= n_a;
                    r_state <= S_AT_W;
                end
                S_AT_W: if (w_done) r_state <= S_T;
                S_T: begin
                    r_t     <= n_t;
                    r_state <= S_VN;
                end
                S_VN: begin
                    r_vnew  <= n_vnew;
                    r_state <= S_SUM;
                end
                S_SUM:  r_state <= S_PS_W;
                S_PS_W: if (w_done) r_state <= S_POS;
                S_POS: begin
                    r_pos   <= n_pos;
                    r_vel   <= r_vnew;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        r_o_pos         <= r_pos;
                        r_o_vel         <= r_vel;
                        r_o_acc         <= r_a;
                        r_o_mode_before <= r_mode_before;
                        r_o_mode_after  <= r_mode;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_mode_before  = r_o_mode_before;
    assign o_mode_after   = r_o_mode_after;

endmodule

>>> sv/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Trapezoidal velocity profile generator, one control tick per item.
// ----------------------------------------------------------------------------
// Each accepted item is one control tick carrying a velocity noise sample; it
// yields exactly one result with the new position, velocity, the acceleration
// applied and the mode before and after the tick. Items are handled one at a
// time: the next item is only accepted once the last one's result has been
// written to the output register. The bit-serial multiply-accumulate unit
// takes one multiplier bit per cycle for the four products of a tick: v*v and
// 2*dec_max*distance for the braking test, then two products by time_step.
// A result waiting in the output register does not hold off the next item,
// only the write of its own result. Configuration writes take effect at once
// and are meant for an idle block.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [WORD_BITS-1:0]              i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [WORD_BITS-1:0]              i_vel_noise,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [WORD_BITS-1:0]              o_position,
    output logic [WORD_BITS-1:0]              o_velocity,
    output logic [WORD_BITS-1:0]              o_acceleration,
    output logic [1:0]                        o_mode_before,
    output logic [1:0]                        o_mode_after
);
    import tmp_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int AW = WORD_BITS - 1;
    localparam logic [AW-1:0] ACC_RST = AW'(64'd4 << FRAC_BITS);
    localparam logic [W-1:0]  DEC_RST = W'(64'd0 - (64'd4 << FRAC_BITS));
    localparam logic [AW-1:0] VMX_RST = AW'(64'd15 << FRAC_BITS);
    localparam logic [W-1:0]  TGT_RST = W'(64'd100 << FRAC_BITS);
    localparam logic [W-1:0]  STP_RST = W'(64'd10 << FRAC_BITS);
    localparam logic [TS_BITS-1:0] TS_RST =
        TS_BITS'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);

    logic [AW-1:0]      r_acc_max;
    logic [W-1:0]       r_dec_max;
    logic [AW-1:0]      r_v_max;
    logic [W-1:0]       r_target;
    logic [W-1:0]       r_stop;
    logic [TS_BITS-1:0] r_time_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_max   <= ACC_RST;
            r_dec_max   <= DEC_RST;
            r_v_max     <= VMX_RST;
            r_target    <= TGT_RST;
            r_stop      <= STP_RST;
            r_time_step <= TS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACC_MAX:   r_acc_max   <= i_cfg_data[AW-1:0];
                CFG_DEC_MAX:   r_dec_max   <= i_cfg_data;
                CFG_V_MAX:     r_v_max     <= i_cfg_data[AW-1:0];
                CFG_TARGET:    r_target    <= i_cfg_data;
                CFG_STOP:      r_stop      <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data[TS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    tmp_core #(
        .W (WORD_BITS),
        .F (FRAC_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc_max      (r_acc_max),
        .i_dec_max      (r_dec_max),
        .i_v_max        (r_v_max),
        .i_target       (r_target),
        .i_stop         (r_stop),
        .i_time_step    (r_time_step),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vel_noise    (i_vel_noise),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_mode_before  (o_mode_before),
        .o_mode_after   (o_mode_after)
    );

endmodule
